>>> sv/mini_rv32_instruction_step_macros.svh
// Assertion macros for the mini RV32 instruction step core.
// Included by the top level; no other dependencies.
`ifndef MINI_RV32_INSTRUCTION_STEP_MACROS_SVH
`define MINI_RV32_INSTRUCTION_STEP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define MRV_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define MRV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/mrv_pkg.sv
// Shared types and constants for the mini RV32 instruction step core.
// No dependencies.
package mrv_pkg;

    // Item opcodes
    localparam logic OP_LOAD_WORD = 1'b0;
    localparam logic OP_EXEC      = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_RUN       = 2'd0;
    localparam logic [1:0] ST_HALT_ZERO = 2'd1;
    localparam logic [1:0] ST_HALT_NZ   = 2'd2;
    localparam logic [1:0] ST_ILLEGAL   = 2'd3;

    // RV32 major opcodes
    localparam logic [6:0] OPC_JALR  = 7'b1100111;
    localparam logic [6:0] OPC_OPIMM = 7'b0010011;
    localparam logic [6:0] OPC_OP    = 7'b0110011;
    localparam logic [6:0] OPC_LUI   = 7'b0110111;
    localparam logic [6:0] OPC_LOAD  = 7'b0000011;
    localparam logic [6:0] OPC_STORE = 7'b0100011;
    localparam logic [6:0] OPC_SYS   = 7'b1110011;

    // funct fields
    localparam logic [2:0] F3_ZERO = 3'b000;
    localparam logic [2:0] F3_WORD = 3'b010;
    localparam logic [2:0] F3_BU   = 3'b100;
    localparam logic [6:0] F7_ZERO = 7'b0000000;

    localparam logic [31:0] INSN_EBREAK = 32'h0010_0073;
    localparam logic [31:0] LUI_MASK    = 32'hFFFF_F000;
    localparam logic [4:0]  REG_ZERO    = 5'd0;
    localparam logic [4:0]  REG_A0      = 5'd10;

    typedef struct packed {
        logic        opcode;
        logic [13:0] load_word_index;
        logic [31:0] load_word_data;
    } t_in_item;

    typedef struct packed {
        logic [31:0] next_pc;
        logic [1:0]  status;
        logic        reg_written;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
    } t_out_item;

endpackage

>>> sv/mrv_stream_if.sv
// Valid/ready stream interface carrying one typed word per handshake.
// Payload type is supplied by the instantiating level (see mrv_pkg).
interface mrv_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/mrv_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mrv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

>>> sv/mini_rv32_instruction_step.sv
// Mini RV32 core (JALR, ADDI, ADD, LUI, LW, LBU, SW, SB, EBREAK) stepping one
// instruction per input word. Uses mrv_pkg, mrv_stream_if, mrv_ram and the macros header.
//
// A program-write word writes memory on acceptance and then goes to the output
// stage. An execute word passes the fetch read from the byte-lane RAMs, the
// register file RAM read, data access or result, for LW/LBU a load write-back,
// then the output stage; a step on a halted core goes straight to the output
// stage. Byte memory and register file RAM reads are registered. The input
// is ready again as soon as a result has moved into the output register, even
// while that result waits to be taken. Byte memory is four 8-bit lanes of
// MEM_BYTES/4 rows, so any unaligned word is one access; MEM_BYTES must be a
// power of two. Memory contents are undefined until written and need no
// clearing; the register file comes out of reset reading zero.
`include "mini_rv32_instruction_step_macros.svh"

module mini_rv32_instruction_step #(
    parameter int MEM_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mrv_stream_if.sink   i_in,
    mrv_stream_if.source o_out
);
    import mrv_pkg::*;

    localparam int ADDR_W = $clog2(MEM_BYTES);
    localparam int ROW_W  = ADDR_W - 2;
    localparam int ROWS   = MEM_BYTES / 4;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FETCH = 5'b00010,
        S_REG   = 5'b00100,
        S_MEM   = 5'b01000,
        S_PUSH  = 5'b10000
    } t_state;

    t_state      r_state, n_state;
    logic [31:0] r_pc, n_pc;
    logic        r_halt, n_halt;
    logic        r_a0_nz, n_a0_nz;
    logic [31:0] r_vld, n_vld;
    logic [31:0] r_instr, n_instr;
    logic [1:0]  r_mlo, n_mlo;
    logic [4:0]  r_rd, n_rd;
    logic        r_is_lw, n_is_lw;
    t_out_item   r_res, n_res;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;

    // Memory access request
    logic [31:0] m_addr;
    logic [31:0] m_wdata;
    logic [3:0]  m_we_k;

    // Byte lanes
    logic [ROW_W-1:0] lane_row [4];
    logic             lane_we  [4];
    logic [7:0]       lane_wd  [4];
    logic [7:0]       lane_q   [4];
    logic [31:0]      rd_word;

    // Register file ports
    logic        rf_we;
    logic [4:0]  rf_waddr;
    logic [31:0] rf_wdata;
    logic [31:0] rf1_q, rf2_q;

    // Decode
    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [4:0]  rd, rs1, rs2;
    logic [31:0] rs1v, rs2v, immi, imms, agu, pc4, add_sum;
    logic        is_jalr, is_addi, is_add, is_lui, is_lw, is_lbu, is_sw, is_sb, is_ebreak;
    logic        legal, dest, wr;
    logic [31:0] val, npc;
    logic [1:0]  halt_st;
    logic        out_free;
    logic [31:0] ld_val;

    // Lane address and data steering: lane l holds byte k = l - addr[1:0]
    always_comb begin
        logic [1:0] k;
        for (int l = 0; l < 4; l++) begin
            k           = 2'(l) - m_addr[1:0];
            lane_row[l] = m_addr[ADDR_W-1:2]
                        + {{(ROW_W-1){1'b0}}, (2'(l) < m_addr[1:0])};
            lane_we[l]  = m_we_k[k];
            lane_wd[l]  = m_wdata[{k, 3'b000} +: 8];
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_lane
        mrv_ram #(.WIDTH(8), .DEPTH(ROWS)) u_lane (
            .i_clk   (i_clk),
            .i_we    (lane_we[g]),
            .i_waddr (lane_row[g]),
            .i_wdata (lane_wd[g]),
            .i_raddr (lane_row[g]),
            .o_rdata (lane_q[g])
        );
    end

    // Reassemble the word read at the registered low address bits
    always_comb begin
        logic [1:0] sel;
        for (int k = 0; k < 4; k++) begin
            sel                 = 2'(k) + r_mlo;
            rd_word[8*k +: 8]   = lane_q[sel];
        end
    end

    // Register file: two copies give two read ports
    mrv_ram #(.WIDTH(32), .DEPTH(32)) u_rf1 (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_raddr (rd_word[19:15]),
        .o_rdata (rf1_q)
    );

    mrv_ram #(.WIDTH(32), .DEPTH(32)) u_rf2 (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_raddr (rd_word[24:20]),
        .o_rdata (rf2_q)
    );

    // Instruction decode and execute datapath
    always_comb begin
        opc  = r_instr[6:0];
        f3   = r_instr[14:12];
        rd   = r_instr[11:7];
        rs1  = r_instr[19:15];
        rs2  = r_instr[24:20];
        rs1v = r_vld[rs1] ? rf1_q : '0;
        rs2v = r_vld[rs2] ? rf2_q : '0;
        immi = {{20{r_instr[31]}}, r_instr[31:20]};
        imms = {{20{r_instr[31]}}, r_instr[31:25], r_instr[11:7]};

        is_jalr   = (opc == OPC_JALR)  && (f3 == F3_ZERO);
        is_addi   = (opc == OPC_OPIMM) && (f3 == F3_ZERO);
        is_add    = (opc == OPC_OP)    && (f3 == F3_ZERO) && (r_instr[31:25] == F7_ZERO);
        is_lui    = (opc == OPC_LUI);
        is_lw     = (opc == OPC_LOAD)  && (f3 == F3_WORD);
        is_lbu    = (opc == OPC_LOAD)  && (f3 == F3_BU);
        is_sw     = (opc == OPC_STORE) && (f3 == F3_WORD);
        is_sb     = (opc == OPC_STORE) && (f3 == F3_ZERO);
        is_ebreak = (r_instr == INSN_EBREAK);
        legal     = is_jalr | is_addi | is_add | is_lui | is_lw | is_lbu
                  | is_sw | is_sb | is_ebreak;
        dest      = is_jalr | is_addi | is_add | is_lui | is_lw | is_lbu;

        agu     = rs1v + ((opc == OPC_STORE) ? imms : immi);
        pc4     = r_pc + 32'd4;
        add_sum = rs1v + rs2v;

        if (is_jalr) begin
            val = pc4;
        end else if (is_addi) begin
            val = agu;
        end else if (is_add) begin
            val = add_sum;
        end else begin
            val = r_instr & LUI_MASK;
        end

        if (is_jalr) begin
            npc = agu & ~32'd1;
        end else if (is_ebreak || !legal) begin
            npc = r_pc;
        end else begin
            npc = pc4;
        end

        wr      = dest && (rd != REG_ZERO);
        halt_st = r_a0_nz ? ST_HALT_NZ : ST_HALT_ZERO;
        ld_val  = r_is_lw ? rd_word : {24'd0, rd_word[7:0]};
    end

    assign out_free = !r_out_valid || o_out.ready;

    // Sequencer and next-state logic
    always_comb begin
        n_state  = r_state;
        n_pc     = r_pc;
        n_halt   = r_halt;
        n_instr  = r_instr;
        n_mlo    = r_mlo;
        n_rd     = r_rd;
        n_is_lw  = r_is_lw;
        n_res    = r_res;
        n_out    = r_out;
        m_addr   = {r_pc[31:2], 2'b00};
        m_wdata  = i_in.data.load_word_data;
        m_we_k   = 4'b0000;
        rf_we    = 1'b0;
        rf_waddr = rd;
        rf_wdata = val;

        n_out_valid = r_out_valid && !o_out.ready;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_res = '{next_pc: r_pc, status: (r_halt ? halt_st : ST_RUN),
                              reg_written: 1'b0, reg_index: '0, reg_value: '0};
                    if (i_in.data.opcode == OP_LOAD_WORD) begin
                        m_addr  = {16'd0, i_in.data.load_word_index, 2'b00};
                        m_we_k  = 4'b1111;
                        n_state = S_PUSH;
                    end else if (r_halt) begin
                        n_state = S_PUSH;
                    end else begin
                        // fetch the aligned word holding pc
                        n_mlo   = 2'b00;
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                n_instr = rd_word;
                n_state = S_REG;
            end
            S_REG: begin
                m_addr  = agu;
                m_wdata = rs2v;
                m_we_k  = is_sw ? 4'b1111 : (is_sb ? 4'b0001 : 4'b0000);
                n_mlo   = agu[1:0];
                n_rd    = rd;
                n_is_lw = is_lw;
                if (is_lw || is_lbu) begin
                    n_pc    = pc4;
                    n_state = S_MEM;
                end else begin
                    n_pc   = npc;
                    n_halt = r_halt | is_ebreak;
                    rf_we  = wr;
                    n_res  = '{next_pc: npc,
                               status: (!legal ? ST_ILLEGAL
                                       : (is_ebreak ? halt_st : ST_RUN)),
                               reg_written: wr,
                               reg_index: (wr ? rd : REG_ZERO),
                               reg_value: (wr ? val : 32'd0)};
                    n_state = S_PUSH;
                end
            end
            S_MEM: begin
                rf_waddr = r_rd;
                rf_wdata = ld_val;
                rf_we    = (r_rd != REG_ZERO);
                n_res    = '{next_pc: r_pc, status: ST_RUN,
                             reg_written: rf_we,
                             reg_index: (rf_we ? r_rd : REG_ZERO),
                             reg_value: (rf_we ? ld_val : 32'd0)};
                n_state  = S_PUSH;
            end
            S_PUSH: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Register valid bits and the a0 shadow flag follow register writes
    always_comb begin
        n_vld   = r_vld;
        n_a0_nz = r_a0_nz;
        if (rf_we) begin
            n_vld[rf_waddr] = 1'b1;
            if (rf_waddr == REG_A0) begin
                n_a0_nz = (rf_wdata != 32'd0);
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_halt      <= 1'b0;
            r_a0_nz     <= 1'b0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_halt      <= n_halt;
            r_a0_nz     <= n_a0_nz;
            r_vld       <= n_vld;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_instr <= n_instr;
        r_mlo   <= n_mlo;
        r_rd    <= n_rd;
        r_is_lw <= n_is_lw;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // Checks
    `MRV_ASSERT_IMPL(a_x0_never_valid, i_clk, i_rst_n, 1'b1, !r_vld[0], "x0 marked written")
    `MRV_ASSERT_IMPL(a_rf_no_x0_write, i_clk, i_rst_n, rf_we, rf_waddr != REG_ZERO, "write to x0")
    `MRV_ASSERT_NEXT(a_halt_pc_hold, i_clk, i_rst_n, r_halt, r_halt && (r_pc == $past(r_pc)), "pc moved while halted")

endmodule
